@@ design/dhcp_client_lease_fsm_assert.svh @@
// Assertion macros used by the DHCP client lease control block.
`ifndef DHCP_CLIENT_LEASE_FSM_ASSERT_SVH
`define DHCP_CLIENT_LEASE_FSM_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define DHCPC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dhcpc assertion failed");

// Next-cycle implication, disabled while in reset.
`define DHCPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dhcpc assertion failed");

`endif

@@ design/dhcpc_pkg.sv @@
// Types and codes for the DHCP client lease controller.
package dhcpc_pkg;

  // Phases
  localparam logic [2:0] PH_OFF        = 3'd0;
  localparam logic [2:0] PH_SELECTING  = 3'd1;
  localparam logic [2:0] PH_REQUESTING = 3'd2;
  localparam logic [2:0] PH_BOUND      = 3'd3;
  localparam logic [2:0] PH_RENEWING   = 3'd4;
  localparam logic [2:0] PH_REBINDING  = 3'd5;
  localparam logic [2:0] PH_FAILED     = 3'd6;
  localparam logic [2:0] PH_UNUSED     = 3'd7;

  // Events
  localparam logic [1:0] EV_START = 2'd0;
  localparam logic [1:0] EV_STOP  = 2'd1;
  localparam logic [1:0] EV_PKT   = 2'd2;
  localparam logic [1:0] EV_TIMER = 2'd3;

  // Received message types
  localparam logic [1:0] MSG_OTHER = 2'd0;
  localparam logic [1:0] MSG_OFFER = 2'd1;
  localparam logic [1:0] MSG_ACK   = 2'd2;
  localparam logic [1:0] MSG_NAK   = 2'd3;

  // Packets to send
  localparam logic [2:0] SEND_NONE     = 3'd0;
  localparam logic [2:0] SEND_DISCOVER = 3'd1;
  localparam logic [2:0] SEND_REQUEST  = 3'd2;
  localparam logic [2:0] SEND_RENEW    = 3'd3;
  localparam logic [2:0] SEND_REBIND   = 3'd4;
  localparam logic [2:0] SEND_RELEASE  = 3'd5;

  // Timer actions
  localparam logic [1:0] TMR_LEAVE  = 2'd0;
  localparam logic [1:0] TMR_CANCEL = 2'd1;
  localparam logic [1:0] TMR_START  = 2'd2;

  // Interface setup actions
  localparam logic [1:0] SETUP_NONE   = 2'd0;
  localparam logic [1:0] SETUP_BIND   = 2'd1;
  localparam logic [1:0] SETUP_UPDATE = 2'd2;

  // Lease fractions in milliseconds per lease second
  localparam logic [8:0] BOUND_FACTOR  = 9'd500;
  localparam logic [8:0] RENEW_FACTOR  = 9'd375;
  localparam logic [8:0] REBIND_FACTOR = 9'd125;

  localparam logic [3:0] CNT_MAX = 4'd15;

  // Configuration register indexes
  localparam logic [1:0] CFG_MAX_ATTEMPTS = 2'd0;
  localparam logic [1:0] CFG_FIRST_WAIT   = 2'd1;
  localparam logic [1:0] CFG_WAIT_STEP    = 2'd2;
  localparam logic [1:0] CFG_REQ_WAIT     = 2'd3;

  // Configuration reset values
  localparam logic [3:0]  MAX_ATTEMPTS_RST = 4'd5;
  localparam logic [15:0] FIRST_WAIT_RST   = 16'd500;
  localparam logic [15:0] WAIT_STEP_RST    = 16'd2000;
  localparam logic [15:0] REQ_WAIT_RST     = 16'd4000;

  localparam int TMO_W = 41;

  typedef struct packed {
    logic [1:0]  func;
    logic [1:0]  msg_type;
    logic [31:0] lease_seconds;
  } dhcpc_in_t;

  typedef struct packed {
    logic [2:0]       send_kind;
    logic [1:0]       timer_cmd;
    logic [TMO_W-1:0] timeout_ms;
    logic [1:0]       setup_kind;
    logic [2:0]       phase;
  } dhcpc_out_t;

  typedef struct packed {
    logic [3:0]  max_attempts;
    logic [15:0] first_wait_ms;
    logic [15:0] wait_step_ms;
    logic [15:0] request_wait_ms;
  } dhcpc_cfg_t;

endpackage

@@ design/dhcpc_cfg.sv @@
// Configuration registers of the DHCP client lease controller.
module dhcpc_cfg (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_addr,
  input  logic [15:0]           cfg_wdata,
  output dhcpc_pkg::dhcpc_cfg_t cfg
);

  dhcpc_pkg::dhcpc_cfg_t cfg_r;
  dhcpc_pkg::dhcpc_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        dhcpc_pkg::CFG_MAX_ATTEMPTS: cfg_nxt.max_attempts    = cfg_wdata[3:0];
        dhcpc_pkg::CFG_FIRST_WAIT:   cfg_nxt.first_wait_ms   = cfg_wdata;
        dhcpc_pkg::CFG_WAIT_STEP:    cfg_nxt.wait_step_ms    = cfg_wdata;
        dhcpc_pkg::CFG_REQ_WAIT:     cfg_nxt.request_wait_ms = cfg_wdata;
        default:                     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_attempts    <= dhcpc_pkg::MAX_ATTEMPTS_RST;
      cfg_r.first_wait_ms   <= dhcpc_pkg::FIRST_WAIT_RST;
      cfg_r.wait_step_ms    <= dhcpc_pkg::WAIT_STEP_RST;
      cfg_r.request_wait_ms <= dhcpc_pkg::REQ_WAIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ design/dhcpc_ctrl.sv @@
// Lease state registers and the per-event decision logic.
`include "dhcp_client_lease_fsm_assert.svh"

module dhcpc_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  dhcpc_pkg::dhcpc_in_t  item,
  input  dhcpc_pkg::dhcpc_cfg_t cfg,
  output dhcpc_pkg::dhcpc_out_t res
);

  logic [2:0]  phase_r, phase_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [31:0] lease_r, lease_nxt;

  logic [2:0]  ph;
  logic [2:0]  send;
  logic [1:0]  tcmd;
  logic [1:0]  setup;
  logic        disc;
  logic [3:0]  disc_base;
  logic [3:0]  cnt_inc;

  logic [3:0]  wait_n;
  logic [19:0] step_prod;
  logic [20:0] offer_wait;
  logic [8:0]  factor;
  logic [40:0] lease_mul;
  logic [40:0] tmo;

  always_comb begin
    ph        = (phase_r == dhcpc_pkg::PH_UNUSED) ? dhcpc_pkg::PH_OFF : phase_r;
    send      = dhcpc_pkg::SEND_NONE;
    tcmd      = dhcpc_pkg::TMR_LEAVE;
    setup     = dhcpc_pkg::SETUP_NONE;
    phase_nxt = ph;
    cnt_nxt   = cnt_r;
    lease_nxt = lease_r;
    disc      = 1'b0;
    disc_base = cnt_r;

    unique case (item.func)
      dhcpc_pkg::EV_START: begin
        disc      = 1'b1;
        disc_base = 4'd0;
      end
      dhcpc_pkg::EV_STOP: begin
        if (ph >= dhcpc_pkg::PH_REQUESTING && ph <= dhcpc_pkg::PH_REBINDING) begin
          send = dhcpc_pkg::SEND_RELEASE;
        end
        tcmd      = dhcpc_pkg::TMR_CANCEL;
        phase_nxt = dhcpc_pkg::PH_OFF;
      end
      dhcpc_pkg::EV_PKT: begin
        unique case (ph) inside
          dhcpc_pkg::PH_SELECTING: begin
            tcmd = dhcpc_pkg::TMR_START;
            if (item.msg_type == dhcpc_pkg::MSG_OFFER) begin
              send      = dhcpc_pkg::SEND_REQUEST;
              phase_nxt = dhcpc_pkg::PH_REQUESTING;
            end
          end
          dhcpc_pkg::PH_REQUESTING: begin
            if (item.msg_type == dhcpc_pkg::MSG_ACK) begin
              lease_nxt = item.lease_seconds;
              setup     = dhcpc_pkg::SETUP_BIND;
              phase_nxt = dhcpc_pkg::PH_BOUND;
              tcmd      = dhcpc_pkg::TMR_START;
            end else if (item.msg_type == dhcpc_pkg::MSG_NAK) begin
              disc = 1'b1;
            end else begin
              tcmd = dhcpc_pkg::TMR_START;
            end
          end
          dhcpc_pkg::PH_BOUND: begin
            tcmd = dhcpc_pkg::TMR_START;
          end
          dhcpc_pkg::PH_RENEWING, dhcpc_pkg::PH_REBINDING: begin
            if (item.msg_type == dhcpc_pkg::MSG_ACK) begin
              lease_nxt = item.lease_seconds;
              setup     = dhcpc_pkg::SETUP_UPDATE;
              phase_nxt = dhcpc_pkg::PH_BOUND;
              tcmd      = dhcpc_pkg::TMR_START;
            end else if (item.msg_type == dhcpc_pkg::MSG_NAK) begin
              disc      = 1'b1;
              disc_base = 4'd0;
            end else begin
              // resend the pending renew or rebind
              send = (ph == dhcpc_pkg::PH_RENEWING) ? dhcpc_pkg::SEND_RENEW
                                                    : dhcpc_pkg::SEND_REBIND;
              tcmd = dhcpc_pkg::TMR_START;
            end
          end
          default: begin
            phase_nxt = ph;
          end
        endcase
      end
      dhcpc_pkg::EV_TIMER: begin
        tcmd = dhcpc_pkg::TMR_CANCEL;
        unique case (ph) inside
          dhcpc_pkg::PH_SELECTING, dhcpc_pkg::PH_REQUESTING: begin
            disc = 1'b1;
          end
          dhcpc_pkg::PH_BOUND: begin
            phase_nxt = dhcpc_pkg::PH_RENEWING;
            send      = dhcpc_pkg::SEND_RENEW;
            tcmd      = dhcpc_pkg::TMR_START;
          end
          dhcpc_pkg::PH_RENEWING: begin
            phase_nxt = dhcpc_pkg::PH_REBINDING;
            send      = dhcpc_pkg::SEND_REBIND;
            tcmd      = dhcpc_pkg::TMR_START;
          end
          dhcpc_pkg::PH_REBINDING: begin
            disc      = 1'b1;
            disc_base = 4'd0;
          end
          default: begin
            phase_nxt = ph;
          end
        endcase
      end
      default: begin
        phase_nxt = ph;
      end
    endcase

    // discover attempt: bump the count, give up at the limit
    cnt_inc = (disc_base == dhcpc_pkg::CNT_MAX) ? disc_base : disc_base + 4'd1;
    if (disc) begin
      cnt_nxt = cnt_inc;
      if (cnt_inc >= cfg.max_attempts) begin
        phase_nxt = dhcpc_pkg::PH_FAILED;
        tcmd      = dhcpc_pkg::TMR_CANCEL;
      end else begin
        send      = dhcpc_pkg::SEND_DISCOVER;
        phase_nxt = dhcpc_pkg::PH_SELECTING;
        tcmd      = dhcpc_pkg::TMR_START;
      end
    end
  end

  // Wait lengths; which one applies follows from the phase being entered.
  always_comb begin
    wait_n     = (cnt_nxt == 4'd0) ? 4'd0 : cnt_nxt - 4'd1;
    step_prod  = {16'd0, wait_n} * {4'd0, cfg.wait_step_ms};
    offer_wait = {5'd0, cfg.first_wait_ms} + {1'b0, step_prod};

    unique case (phase_nxt) inside
      dhcpc_pkg::PH_RENEWING:  factor = dhcpc_pkg::RENEW_FACTOR;
      dhcpc_pkg::PH_REBINDING: factor = dhcpc_pkg::REBIND_FACTOR;
      default:                 factor = dhcpc_pkg::BOUND_FACTOR;
    endcase
    lease_mul = {9'd0, lease_nxt} * {32'd0, factor};

    tmo = '0;
    if (tcmd == dhcpc_pkg::TMR_START) begin
      unique case (phase_nxt) inside
        dhcpc_pkg::PH_SELECTING:  tmo = {20'd0, offer_wait};
        dhcpc_pkg::PH_REQUESTING: tmo = {25'd0, cfg.request_wait_ms};
        default:                  tmo = lease_mul;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= dhcpc_pkg::PH_OFF;
      cnt_r   <= 4'd0;
      lease_r <= 32'd0;
    end else if (adv) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      lease_r <= lease_nxt;
    end
  end

  always_comb begin
    res.send_kind  = send;
    res.timer_cmd  = tcmd;
    res.timeout_ms = tmo;
    res.setup_kind = setup;
    res.phase      = phase_nxt;
  end

  `DHCPC_ASSERT_NEXT(a_hold_state, !adv,
    $stable(phase_r) && $stable(cnt_r) && $stable(lease_r))
  `DHCPC_ASSERT_NEXT(a_lease_taken, adv && res.setup_kind != dhcpc_pkg::SETUP_NONE,
    lease_r == $past(item.lease_seconds))
  `DHCPC_ASSERT_SAME(a_select_counted, phase_r == dhcpc_pkg::PH_SELECTING, cnt_r != 4'd0)
  `DHCPC_ASSERT_SAME(a_idle_timer, tcmd != dhcpc_pkg::TMR_START, res.timeout_ms == '0)

endmodule

@@ design/dhcp_client_lease_fsm.sv @@
// Top level of the DHCP client lease controller.
//
//   port group  direction  handshake         payload
//   in_         input      in_valid/ready    dhcpc_in_t (event, message, lease)
//   out_        output     out_valid/ready   dhcpc_out_t (command, phase)
//   cfg_        input      cfg_we            cfg_addr index, cfg_wdata value
//
// Each item is held in the input register while its command is decided; the command
// then lands in the output register, where out_valid rises and the result can be taken.
// One item is accepted per cycle while the output is not stalled;
// the state update and result write share one edge.
// A stalled output holds both registers; the input register drains as out_ready returns.
// Reset (synchronous, rst_n low) clears the phase to off, the counters, and config defaults.
module dhcp_client_lease_fsm (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  dhcpc_pkg::dhcpc_in_t  in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output dhcpc_pkg::dhcpc_out_t out_item,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_addr,
  input  logic [15:0]           cfg_wdata
);

  logic                  s1_valid_r;
  dhcpc_pkg::dhcpc_in_t  s1_item_r;
  logic                  out_valid_r;
  dhcpc_pkg::dhcpc_out_t out_item_r;
  logic                  adv;
  dhcpc_pkg::dhcpc_cfg_t cfg;
  dhcpc_pkg::dhcpc_out_t res;

  // advance the held item when the output register is free or being taken
  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item_r <= in_item;
    end
    if (adv) begin
      out_item_r <= res;
    end
  end

  dhcpc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  dhcpc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .item  (s1_item_r),
    .cfg   (cfg),
    .res   (res)
  );

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
